@@ rtl/contiguous_page_allocator_unit_defines.svh @@
// Assertion macros used by the checker file of the page allocator.
// No dependencies; included by bare file name.
`ifndef CONTIGUOUS_PAGE_ALLOCATOR_UNIT_DEFINES_SVH
`define CONTIGUOUS_PAGE_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, masked during reset
`define CPA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("page allocator port check failed");

// Next-cycle implication, masked during reset
`define CPA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("page allocator port check failed");

`endif

@@ rtl/cpa_pkg.sv @@
// Shared constants, codes and structs for the contiguous page allocator.
// No dependencies; imported by every module of the block.
package cpa_pkg;

    // Map geometry (PAGE_BYTES must be a power of two)
    localparam int NUM_PAGES  = 256;
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int ADDR_W     = 32;
    localparam int LEN_W      = 9;
    localparam int IDX_W      = $clog2(NUM_PAGES);
    localparam int CNT_W      = $clog2(NUM_PAGES + 1);
    localparam int WIDE_W     = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int HI_W       = WIDE_W + 1;
    localparam int FRM_W      = ADDR_W - PAGE_SHIFT;

    // Configuration port
    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_BASE     = 2'd0;
    localparam logic [1:0] REG_MANAGED  = 2'd1;
    localparam logic [1:0] REG_RESERVED = 2'd2;
    localparam logic [LEN_W-1:0] MANAGED_RST = LEN_W'(256);

    // Request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_ROOM   = 2'd1,
        ST_NOT_BLOCK = 2'd2
    } t_status;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_MARK  = 6'b000100,
        S_RREAD = 6'b001000,
        S_RCHK  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    // Search token passed cell to cell
    typedef struct packed {
        logic              vld;
        logic              found;
        logic [WIDE_W-1:0] cnt;
        logic [IDX_W-1:0]  last;
    } t_token;

    // Search settings seen by every cell
    typedef struct packed {
        logic [WIDE_W-1:0] want;
        logic [WIDE_W-1:0] live;
        logic [WIDE_W-1:0] rsvd;
    } t_scan_cfg;

    // Range update broadcast to the cells: lo <= index < hi
    typedef struct packed {
        logic            set;
        logic            clr;
        logic [HI_W-1:0] lo;
        logic [HI_W-1:0] hi;
    } t_range_cmd;

endpackage

@@ rtl/contiguous_page_allocator_unit.sv @@
// Contiguous page allocator: first-fit run search over a frame map.
// Requests enter on the s_axis channel; one result per request leaves on m_axis.
// Allocate (tuser 0): first run of page_count_req free frames from frame 0 up,
// answered with its address; release (tuser 1): frees the block at phys_addr.
// Registers (APB): base_addr @0x0, managed_pages @0x4, reserved_pages @0x8.
// An allocate launches a search token that walks the cell row one frame per
// cycle; the run it finds is then marked used (no mark step when no run is
// found, as there is nothing to mark) and the result is made.
// Zero-page allocates skip the search; releases read the run length memory.
// One request is in flight at a time; the next is taken once the result is
// in the output register, even while the receiver has not yet taken it.
// A stalled receiver holds the result and blocks only the next completion.
// Reset (synchronous) frees every frame, clears all run lengths through
// per-entry valid bits (no clearing pass) and restores register defaults.
// Configuration writes are expected only while no request is in flight.
module contiguous_page_allocator_unit import cpa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // APB configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // Requests
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [47:0]        s_axis_tdata,  // [8:0] page_count_req, [40:9] phys_addr
    input  logic [0:0]         s_axis_tuser,  // [0] req_type
    // Results
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [31:0]        m_axis_tdata,  // [31:0] result_addr
    output logic [1:0]         m_axis_tuser   // [1:0] status
);

    t_state r_state;
    t_state n_state;

    logic [ADDR_W-1:0] r_base;
    logic [LEN_W-1:0]  r_managed;
    logic [LEN_W-1:0]  r_reserved;

    logic [LEN_W-1:0]  r_want;
    logic [IDX_W-1:0]  r_idx;
    logic              r_hit;
    logic [IDX_W-1:0]  r_end;
    logic [LEN_W-1:0]  r_rd_len;
    logic              r_rd_vld;
    logic [ADDR_W-1:0] r_res_addr;
    t_status           r_status;
    t_token            r_inject;

    logic              r_out_vld;
    logic [ADDR_W-1:0] r_out_addr;
    t_status           r_out_status;

    logic [LEN_W-1:0]  r_run_mem [NUM_PAGES];
    logic [NUM_PAGES-1:0] r_run_vld;

    logic              cfg_wr;
    logic              in_acc;
    logic              in_type;
    logic [LEN_W-1:0]  in_want;
    logic [ADDR_W-1:0] in_addr;
    logic [ADDR_W-1:0] rel_off;
    logic              rel_hit;
    logic [WIDE_W-1:0] managed_w;
    logic [WIDE_W-1:0] live;
    logic [WIDE_W-1:0] start_w;
    logic [IDX_W-1:0]  start_idx;
    logic              out_free;
    logic              rel_ok;
    t_scan_cfg         scan_cfg;
    t_range_cmd        cmd;
    t_token            tail;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= '0;
            r_managed  <= MANAGED_RST;
            r_reserved <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_BASE:     r_base     <= pwdata;
                REG_MANAGED:  r_managed  <= pwdata[LEN_W-1:0];
                REG_RESERVED: r_reserved <= pwdata[LEN_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_BASE:     prdata = r_base;
            REG_MANAGED:  prdata = 32'(r_managed);
            REG_RESERVED: prdata = 32'(r_reserved);
            default:      prdata = '0;
        endcase
    end

    // Request unpacking
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign in_type = s_axis_tuser[0];
    assign in_want = s_axis_tdata[8:0];
    assign in_addr = s_axis_tdata[40:9];

    // Frames the map covers
    assign managed_w = WIDE_W'(r_managed);
    assign live = (managed_w > WIDE_W'(NUM_PAGES)) ? WIDE_W'(NUM_PAGES) : managed_w;

    // Release address to frame index: aligned offset inside the live map
    assign rel_off = in_addr - r_base;
    assign rel_hit = (rel_off[PAGE_SHIFT-1:0] == '0) &&
                     (rel_off[ADDR_W-1:PAGE_SHIFT] < FRM_W'(live));

    // Run start from the frame where the search completed
    assign start_w   = WIDE_W'(r_end) + WIDE_W'(1) - WIDE_W'(r_want);
    assign start_idx = start_w[IDX_W-1:0];

    assign rel_ok   = r_hit && r_rd_vld;
    assign out_free = !r_out_vld || m_axis_tready;

    // Cell row
    assign scan_cfg.want = WIDE_W'(r_want);
    assign scan_cfg.live = live;
    assign scan_cfg.rsvd = WIDE_W'(r_reserved);

    always_comb begin
        cmd = '0;
        if (r_state == S_MARK) begin
            cmd.set = 1'b1;
            cmd.lo  = HI_W'(start_w);
            cmd.hi  = HI_W'(r_end) + HI_W'(1);
        end else if ((r_state == S_RCHK) && rel_ok) begin
            cmd.clr = 1'b1;
            cmd.lo  = HI_W'(r_idx);
            cmd.hi  = HI_W'(r_idx) + HI_W'(r_rd_len);
        end
    end

    cpa_cell_row u_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (scan_cfg),
        .i_cmd   (cmd),
        .i_tok   (r_inject),
        .o_tok   (tail)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (in_type == REQ_FREE) begin
                        n_state = S_RREAD;
                    end else if (in_want == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (tail.vld) begin
                    n_state = tail.found ? S_MARK : S_DONE;
                end
            end
            S_MARK:  n_state = S_DONE;
            S_RREAD: n_state = S_RCHK;
            S_RCHK:  n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and search token launch
    always_ff @(posedge i_clk) begin
        r_inject.found <= 1'b0;
        r_inject.cnt   <= '0;
        r_inject.last  <= '0;
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_inject.vld <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_inject.vld <= in_acc && (in_type == REQ_ALLOC) && (in_want != '0);
        end
    end

    // Request datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_want     <= in_want;
                    r_idx      <= rel_off[PAGE_SHIFT +: IDX_W];
                    r_hit      <= rel_hit;
                    r_res_addr <= '0;
                    r_status   <= ST_NO_ROOM;
                end
            end
            S_SCAN: begin
                r_end <= tail.last;
            end
            S_MARK: begin
                r_res_addr <= r_base + (ADDR_W'(start_idx) << PAGE_SHIFT);
                r_status   <= ST_OK;
            end
            S_RCHK: begin
                r_status <= rel_ok ? ST_OK : ST_NOT_BLOCK;
            end
            default: ;
        endcase
    end

    // Run length memory, data half
    always_ff @(posedge i_clk) begin
        if (r_state == S_MARK) begin
            r_run_mem[start_idx] <= r_want;
        end
        if (r_state == S_RREAD) begin
            r_rd_len <= r_run_mem[r_idx];
        end
    end

    // Run length valid bits: an entry not valid reads as no block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_vld <= '0;
        end else if (r_state == S_MARK) begin
            r_run_vld[start_idx] <= 1'b1;
        end else if ((r_state == S_RCHK) && rel_ok) begin
            r_run_vld[r_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RREAD) begin
            r_rd_vld <= r_run_vld[r_idx];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_out_addr   <= r_res_addr;
            r_out_status <= r_status;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_addr;
    assign m_axis_tuser  = r_out_status;

endmodule

@@ rtl/cpa_cell.sv @@
// One frame cell: holds the frame's used bit and one stage of the search token.
// Depends on cpa_pkg.
module cpa_cell import cpa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_idx,
    input  t_scan_cfg        i_cfg,
    input  t_range_cmd       i_cmd,
    input  t_token           i_tok,
    output t_token           o_tok
);

    logic              r_used;
    logic              n_used;
    t_token            r_tok;
    t_token            n_tok;
    logic [WIDE_W-1:0] idx_w;
    logic [HI_W-1:0]   idx_h;
    logic              taken;
    logic              in_map;
    logic              in_rng;
    logic [WIDE_W-1:0] cnt_nx;

    assign idx_w  = WIDE_W'(i_idx);
    assign idx_h  = HI_W'(i_idx);
    assign taken  = (idx_w < i_cfg.rsvd) || r_used;
    assign in_map = idx_w < i_cfg.live;
    assign in_rng = (idx_h >= i_cmd.lo) && (idx_h < i_cmd.hi);
    assign cnt_nx = taken ? '0 : (i_tok.cnt + WIDE_W'(1));

    // Extend or break the free run carried by the token
    always_comb begin
        n_tok = i_tok;
        if (i_tok.vld && !i_tok.found && in_map) begin
            n_tok.cnt = cnt_nx;
            if (cnt_nx == i_cfg.want) begin
                n_tok.found = 1'b1;
                n_tok.last  = i_idx;
            end
        end
    end

    // Range mark / free
    always_comb begin
        n_used = r_used;
        if (i_cmd.set && in_rng) begin
            n_used = 1'b1;
        end else if (i_cmd.clr && in_rng) begin
            n_used = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= 1'b0;
            r_tok.vld <= 1'b0;
        end else begin
            r_used <= n_used;
            r_tok  <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

@@ rtl/cpa_cell_row.sv @@
// Row of frame cells linked into the search chain, cell 0 at the head.
// Depends on cpa_pkg and cpa_cell.
module cpa_cell_row import cpa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_scan_cfg  i_cfg,
    input  t_range_cmd i_cmd,
    input  t_token     i_tok,
    output t_token     o_tok
);

    t_token w_tok [NUM_PAGES+1];

    assign w_tok[0] = i_tok;

    // Token moves one frame per cycle from the lowest frame upward
    for (genvar g = 0; g < NUM_PAGES; g++) begin : g_cell
        cpa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_cfg   (i_cfg),
            .i_cmd   (i_cmd),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    assign o_tok = w_tok[NUM_PAGES];

endmodule

@@ rtl/cpa_checker.sv @@
// Port-level checks for the page allocator, bound to the top level.
// Depends on cpa_pkg and contiguous_page_allocator_unit_defines.svh.
`include "contiguous_page_allocator_unit_defines.svh"

module cpa_checker import cpa_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // Stalled result holds
    `CPA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // Status is always a defined code
    `CPA_ASSERT_NOW(a_status_code, i_clk, i_rst_n, m_axis_tvalid, (m_axis_tuser == ST_OK) || (m_axis_tuser == ST_NO_ROOM) || (m_axis_tuser == ST_NOT_BLOCK))

    // Failed requests carry a zero address
    `CPA_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tdata == '0)

    // One request at a time: no back-to-back request transfers
    `CPA_ASSERT_NEXT(a_one_at_time, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind contiguous_page_allocator_unit cpa_checker u_cpa_checker (.*);
